// ===== design/joyac_pkg.sv =====
// shared types and constants for the joystick axis conditioner
package joyac_pkg;

   // register and field widths
   localparam int CFG_BITS      = 12;
   localparam int DEAD_BITS     = 11;
   localparam int DIV_BITS      = 12;
   localparam int QUOT_BITS     = 7;
   localparam int NUM_BITS      = DIV_BITS + QUOT_BITS;
   localparam int AXIS_BITS     = 8;
   localparam int CSR_ADDR_BITS = 5;
   localparam int CSR_DATA_BITS = 32;

   // full-scale axis magnitude
   localparam logic signed [AXIS_BITS-1:0] AXIS_FULL = 8'sd127;

   // register reset values
   localparam logic [CFG_BITS-1:0]  LOWER_RESET  = 12'd900;
   localparam logic [CFG_BITS-1:0]  CENTER_RESET = 12'd1910;
   localparam logic [CFG_BITS-1:0]  UPPER_RESET  = 12'd2900;
   localparam logic [DEAD_BITS-1:0] DEAD_RESET   = 11'd0;

   // register index codes
   typedef enum logic [2:0] {
      REG_LOWER_LIMIT  = 3'd0,
      REG_CENTER_LEVEL = 3'd1,
      REG_UPPER_LIMIT  = 3'd2,
      REG_DEAD_BAND    = 3'd3,
      REG_INVERT       = 3'd4
   } reg_index_type;

   // how the axis value is formed at the end of the chain
   typedef enum logic [1:0] {
      KIND_ZERO   = 2'd0,
      KIND_FULL   = 2'd1,
      KIND_SCALED = 2'd2
   } kind_type;

   typedef struct packed {
      logic     neg;
      kind_type kind;
   } axis_ctl_type;

   typedef struct packed {
      logic [CFG_BITS-1:0]  lower_limit;
      logic [CFG_BITS-1:0]  center_level;
      logic [CFG_BITS-1:0]  upper_limit;
      logic [DEAD_BITS-1:0] dead_band;
      logic                 invert;
   } cfg_type;

endpackage

// ===== design/joyac_front.sv =====
// median, inversion, range classification and numerator setup stages
module joyac_front #(
   parameter int SAMPLE_BITS = 12
) (
   input  logic                             clock,
   input  logic                             reset,
   input  joyac_pkg::cfg_type               cfg,
   input  logic                             in_valid,
   output logic                             in_ready,
   input  logic [SAMPLE_BITS-1:0]           in_first,
   input  logic [SAMPLE_BITS-1:0]           in_second,
   input  logic [SAMPLE_BITS-1:0]           in_third,
   output logic                             out_valid,
   input  logic                             out_ready,
   output logic [SAMPLE_BITS-1:0]           out_reading,
   output joyac_pkg::axis_ctl_type          out_ctl,
   output logic [joyac_pkg::NUM_BITS-1:0]   out_num,
   output logic [joyac_pkg::DIV_BITS-1:0]   out_div
);
   import joyac_pkg::*;

   localparam int AW = ((SAMPLE_BITS > CFG_BITS) ? SAMPLE_BITS : CFG_BITS) + 2;

   logic                   a_valid_ff, b_valid_ff, c_valid_ff;
   logic                   a_adv, b_adv, c_adv;
   logic [SAMPLE_BITS-1:0] reading_a_ff, reading_a_in;
   logic [SAMPLE_BITS-1:0] reading_b_ff, reading_c_ff;
   axis_ctl_type           ctl_b_ff, ctl_b_in, ctl_c_ff;
   logic [DIV_BITS-1:0]    diff_b_ff, diff_b_in, div_b_ff, div_b_in, div_c_ff;
   logic [NUM_BITS-1:0]    num_c_ff, num_c_in;
   logic [SAMPLE_BITS-1:0] pair_lo, pair_hi, mid;
   logic signed [AW-1:0]   r, mn, mx, lo, hi, diff_w, div_w;

   // stall chain
   assign c_adv    = !c_valid_ff || out_ready;
   assign b_adv    = !b_valid_ff || c_adv;
   assign a_adv    = !a_valid_ff || b_adv;
   assign in_ready = a_adv;

   // median of three, then optional inversion
   always_comb begin
      pair_lo      = (in_first < in_second) ? in_first : in_second;
      pair_hi      = (in_first < in_second) ? in_second : in_first;
      mid          = (pair_hi < in_third) ? pair_hi : in_third;
      reading_a_in = (pair_lo > mid) ? pair_lo : mid;
      if (cfg.invert) begin
         reading_a_in = ~reading_a_in;
      end
   end

   // classify the reading against the limits and the dead band
   always_comb begin
      r  = $signed({{(AW-SAMPLE_BITS){1'b0}}, reading_a_ff});
      mn = $signed({{(AW-CFG_BITS){1'b0}}, cfg.lower_limit});
      mx = $signed({{(AW-CFG_BITS){1'b0}}, cfg.upper_limit});
      lo = $signed({{(AW-CFG_BITS){1'b0}}, cfg.center_level})
         - $signed({{(AW-DEAD_BITS){1'b0}}, cfg.dead_band});
      hi = $signed({{(AW-CFG_BITS){1'b0}}, cfg.center_level})
         + $signed({{(AW-DEAD_BITS){1'b0}}, cfg.dead_band});
      diff_w = '0;
      div_w  = '0;
      ctl_b_in.neg  = 1'b0;
      ctl_b_in.kind = KIND_ZERO;
      priority if (r <= mn) begin
         ctl_b_in.neg  = 1'b1;
         ctl_b_in.kind = KIND_FULL;
      end else if (r < lo) begin
         ctl_b_in.neg  = 1'b1;
         ctl_b_in.kind = KIND_SCALED;
         diff_w = lo - r;
         div_w  = lo - mn;
      end else if (r <= hi) begin
         ctl_b_in.kind = KIND_ZERO;
      end else if (r < mx) begin
         ctl_b_in.kind = KIND_SCALED;
         diff_w = r - hi;
         div_w  = mx - hi;
      end else begin
         ctl_b_in.kind = KIND_FULL;
      end
      diff_b_in = diff_w[DIV_BITS-1:0];
      div_b_in  = div_w[DIV_BITS-1:0];
   end

   // numerator is diff times full scale
   assign num_c_in = {diff_b_ff, {QUOT_BITS{1'b0}}} - {{QUOT_BITS{1'b0}}, diff_b_ff};

   // stage valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else begin
         if (a_adv) a_valid_ff <= in_valid;
         if (b_adv) b_valid_ff <= a_valid_ff;
         if (c_adv) c_valid_ff <= b_valid_ff;
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (a_adv && in_valid) begin
         reading_a_ff <= reading_a_in;
      end
      if (b_adv && a_valid_ff) begin
         reading_b_ff <= reading_a_ff;
         ctl_b_ff     <= ctl_b_in;
         diff_b_ff    <= diff_b_in;
         div_b_ff     <= div_b_in;
      end
      if (c_adv && b_valid_ff) begin
         reading_c_ff <= reading_b_ff;
         ctl_c_ff     <= ctl_b_ff;
         num_c_ff     <= num_c_in;
         div_c_ff     <= div_b_ff;
      end
   end

   assign out_valid   = c_valid_ff;
   assign out_reading = reading_c_ff;
   assign out_ctl     = ctl_c_ff;
   assign out_num     = num_c_ff;
   assign out_div     = div_c_ff;

endmodule

// ===== design/joyac_cell.sv =====
// one restoring-division cell: decides one quotient bit and hands on
module joyac_cell #(
   parameter int SAMPLE_BITS = 12,
   parameter int SHIFT       = 0
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   output logic                             in_ready,
   input  logic [SAMPLE_BITS-1:0]           in_reading,
   input  joyac_pkg::axis_ctl_type          in_ctl,
   input  logic [joyac_pkg::NUM_BITS-1:0]   in_rem,
   input  logic [joyac_pkg::DIV_BITS-1:0]   in_div,
   input  logic [joyac_pkg::QUOT_BITS-1:0]  in_quot,
   output logic                             out_valid,
   input  logic                             out_ready,
   output logic [SAMPLE_BITS-1:0]           out_reading,
   output joyac_pkg::axis_ctl_type          out_ctl,
   output logic [joyac_pkg::NUM_BITS-1:0]   out_rem,
   output logic [joyac_pkg::DIV_BITS-1:0]   out_div,
   output logic [joyac_pkg::QUOT_BITS-1:0]  out_quot
);
   import joyac_pkg::*;

   logic                   valid_ff, advance;
   logic [SAMPLE_BITS-1:0] reading_ff;
   axis_ctl_type           ctl_ff;
   logic [NUM_BITS-1:0]    rem_ff, rem_in, div_shift;
   logic [DIV_BITS-1:0]    div_ff;
   logic [QUOT_BITS-1:0]   quot_ff, quot_in;
   logic [NUM_BITS:0]      trial;
   logic                   fits;

   assign advance  = !valid_ff || out_ready;
   assign in_ready = advance;

   // trial subtract of the shifted divisor
   always_comb begin
      div_shift     = {{(NUM_BITS-DIV_BITS){1'b0}}, in_div} << SHIFT;
      trial         = {1'b0, in_rem} - {1'b0, div_shift};
      fits          = !trial[NUM_BITS];
      rem_in        = fits ? trial[NUM_BITS-1:0] : in_rem;
      quot_in       = in_quot;
      quot_in[SHIFT] = fits;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_valid) begin
         reading_ff <= in_reading;
         ctl_ff     <= in_ctl;
         rem_ff     <= rem_in;
         div_ff     <= in_div;
         quot_ff    <= quot_in;
      end
   end

   assign out_valid   = valid_ff;
   assign out_reading = reading_ff;
   assign out_ctl     = ctl_ff;
   assign out_rem     = rem_ff;
   assign out_div     = div_ff;
   assign out_quot    = quot_ff;

endmodule

// ===== design/joystick_axis_conditioner_core.sv =====
// top level: joystick axis conditioner with register port and divider cell chain
// throughput: one item per cycle while rsp_ready does not stall the output;
// three front stages, seven divider cells and the output register each hold
// one item, one quotient bit decided per cell
// reset (synchronous, active high) empties the pipeline and loads register defaults
module joystick_axis_conditioner_core #(
   parameter int SAMPLE_BITS = 12
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [joyac_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  logic [joyac_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic [joyac_pkg::CSR_DATA_BITS-1:0]   csr_prdata,
   output logic                                  csr_pready,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [SAMPLE_BITS-1:0]                req_sample_first,
   input  logic [SAMPLE_BITS-1:0]                req_sample_second,
   input  logic [SAMPLE_BITS-1:0]                req_sample_third,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [SAMPLE_BITS-1:0]                rsp_reading,
   output logic signed [joyac_pkg::AXIS_BITS-1:0] rsp_axis_value
);
   import joyac_pkg::*;

   cfg_type                   cfg_ff;
   reg_index_type             csr_index;
   logic                      csr_write;

   logic                      valid_w   [0:QUOT_BITS];
   logic                      ready_w   [0:QUOT_BITS];
   logic [SAMPLE_BITS-1:0]    reading_w [0:QUOT_BITS];
   axis_ctl_type              ctl_w     [0:QUOT_BITS];
   logic [NUM_BITS-1:0]       rem_w     [0:QUOT_BITS];
   logic [DIV_BITS-1:0]       div_w     [0:QUOT_BITS];
   logic [QUOT_BITS-1:0]      quot_w    [0:QUOT_BITS];

   logic                          rsp_valid_ff, out_adv;
   logic [SAMPLE_BITS-1:0]        rsp_reading_ff;
   logic signed [AXIS_BITS-1:0]   axis_ff, axis_in, scaled;

   // register port
   assign csr_pready = 1'b1;
   assign csr_index  = reg_index_type'(csr_paddr[CSR_ADDR_BITS-1:2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.lower_limit  <= LOWER_RESET;
         cfg_ff.center_level <= CENTER_RESET;
         cfg_ff.upper_limit  <= UPPER_RESET;
         cfg_ff.dead_band    <= DEAD_RESET;
         cfg_ff.invert       <= 1'b0;
      end else if (csr_write) begin
         case (csr_index)
            REG_LOWER_LIMIT:  cfg_ff.lower_limit  <= csr_pwdata[CFG_BITS-1:0];
            REG_CENTER_LEVEL: cfg_ff.center_level <= csr_pwdata[CFG_BITS-1:0];
            REG_UPPER_LIMIT:  cfg_ff.upper_limit  <= csr_pwdata[CFG_BITS-1:0];
            REG_DEAD_BAND:    cfg_ff.dead_band    <= csr_pwdata[DEAD_BITS-1:0];
            REG_INVERT:       cfg_ff.invert       <= csr_pwdata[0];
            default: begin
            end
         endcase
      end
   end

   // register readback
   always_comb begin
      csr_prdata = '0;
      case (csr_index)
         REG_LOWER_LIMIT:  csr_prdata[CFG_BITS-1:0]  = cfg_ff.lower_limit;
         REG_CENTER_LEVEL: csr_prdata[CFG_BITS-1:0]  = cfg_ff.center_level;
         REG_UPPER_LIMIT:  csr_prdata[CFG_BITS-1:0]  = cfg_ff.upper_limit;
         REG_DEAD_BAND:    csr_prdata[DEAD_BITS-1:0] = cfg_ff.dead_band;
         REG_INVERT:       csr_prdata[0]             = cfg_ff.invert;
         default:          csr_prdata = '0;
      endcase
   end

   // median, classification and numerator stages
   joyac_front #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .in_valid    (req_valid),
      .in_ready    (req_ready),
      .in_first    (req_sample_first),
      .in_second   (req_sample_second),
      .in_third    (req_sample_third),
      .out_valid   (valid_w[0]),
      .out_ready   (ready_w[0]),
      .out_reading (reading_w[0]),
      .out_ctl     (ctl_w[0]),
      .out_num     (rem_w[0]),
      .out_div     (div_w[0])
   );
   assign quot_w[0] = '0;

   // divider cell chain, most significant quotient bit first
   for (genvar i = 0; i < QUOT_BITS; i++) begin : g_cell
      joyac_cell #(
         .SAMPLE_BITS (SAMPLE_BITS),
         .SHIFT       (QUOT_BITS - 1 - i)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .in_valid    (valid_w[i]),
         .in_ready    (ready_w[i]),
         .in_reading  (reading_w[i]),
         .in_ctl      (ctl_w[i]),
         .in_rem      (rem_w[i]),
         .in_div      (div_w[i]),
         .in_quot     (quot_w[i]),
         .out_valid   (valid_w[i+1]),
         .out_ready   (ready_w[i+1]),
         .out_reading (reading_w[i+1]),
         .out_ctl     (ctl_w[i+1]),
         .out_rem     (rem_w[i+1]),
         .out_div     (div_w[i+1]),
         .out_quot    (quot_w[i+1])
      );
   end

   // final axis value from the quotient and the range class
   assign out_adv            = !rsp_valid_ff || rsp_ready;
   assign ready_w[QUOT_BITS] = out_adv;

   always_comb begin
      scaled = $signed({1'b0, quot_w[QUOT_BITS]});
      unique case (ctl_w[QUOT_BITS].kind)
         KIND_FULL:   axis_in = ctl_w[QUOT_BITS].neg ? -AXIS_FULL : AXIS_FULL;
         KIND_SCALED: axis_in = ctl_w[QUOT_BITS].neg ? -scaled : scaled;
         default:     axis_in = '0;
      endcase
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_adv) begin
         rsp_valid_ff <= valid_w[QUOT_BITS];
      end
   end

   always_ff @(posedge clock) begin
      if (out_adv && valid_w[QUOT_BITS]) begin
         rsp_reading_ff <= reading_w[QUOT_BITS];
         axis_ff        <= axis_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_reading    = rsp_reading_ff;
   assign rsp_axis_value = axis_ff;

   // the axis value never reaches the most negative code
   a_axis_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (axis_ff != -AXIS_FULL - 8'sd1))
      else $error("axis value out of range");

   // a scaled quotient stays below full scale
   a_quot_bound: assert property (@(posedge clock) disable iff (reset)
      (valid_w[QUOT_BITS] && ctl_w[QUOT_BITS].kind == KIND_SCALED)
      |-> (quot_w[QUOT_BITS] != {QUOT_BITS{1'b1}}))
      else $error("scaled quotient reached full scale");

   // an item in the last cell is held while the output is stalled
   a_last_held: assert property (@(posedge clock) disable iff (reset)
      (valid_w[QUOT_BITS] && rsp_valid_ff && !rsp_ready) |=> valid_w[QUOT_BITS])
      else $error("item dropped from last divider cell");

   // input back-pressure only comes from a stalled output
   a_ready_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid_ff && !rsp_ready))
      else $error("input stalled without output back-pressure");

endmodule

// ===== verif/joystick_axis_conditioner_checker.sv =====
// checker for the joystick axis conditioner: predicts each result and compares it
module joystick_axis_conditioner_checker #(
   parameter int SAMPLE_BITS = 12
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_psel,
   input  logic                                   csr_penable,
   input  logic                                   csr_pwrite,
   input  logic                                   csr_pready,
   input  logic [joyac_pkg::CSR_ADDR_BITS-1:0]    csr_paddr,
   input  logic [joyac_pkg::CSR_DATA_BITS-1:0]    csr_pwdata,
   input  logic                                   req_valid,
   input  logic                                   req_ready,
   input  logic [SAMPLE_BITS-1:0]                 req_sample_first,
   input  logic [SAMPLE_BITS-1:0]                 req_sample_second,
   input  logic [SAMPLE_BITS-1:0]                 req_sample_third,
   input  logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   input  logic [SAMPLE_BITS-1:0]                 rsp_reading,
   input  logic signed [joyac_pkg::AXIS_BITS-1:0] rsp_axis_value,
   output int                                     fail_count,
   output int                                     pending_count,
   output int                                     checked_count
);
   import joyac_pkg::*;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0]        reading;
      logic signed [AXIS_BITS-1:0]   axis_value;
   } axis_result_type;

   localparam int FULL_CODE = (1 << SAMPLE_BITS) - 1;

   cfg_type         axis_cfg;
   axis_result_type pending_axis[$];
   axis_result_type want;
   int              fails = 0;
   int              checked = 0;

   // middle one of three conversions
   function automatic int median_of(input int a, input int b, input int c);
      int lo_s;
      int hi_s;
      int m;
      lo_s = (a < b) ? a : b;
      hi_s = (a < b) ? b : a;
      m = (hi_s < c) ? hi_s : c;
      return (lo_s > m) ? lo_s : m;
   endfunction

   // map a reading onto -127..127 with dead band around center
   function automatic logic signed [AXIS_BITS-1:0] scale_to_axis(input int r);
      int mn;
      int mx;
      int lo_edge;
      int hi_edge;
      int v;
      mn = int'(axis_cfg.lower_limit);
      mx = int'(axis_cfg.upper_limit);
      lo_edge = int'(axis_cfg.center_level) - int'(axis_cfg.dead_band);
      hi_edge = int'(axis_cfg.center_level) + int'(axis_cfg.dead_band);
      if (r <= mn)
         v = -127;
      else if (r < lo_edge)
         v = -(((lo_edge - r) * 127) / (lo_edge - mn));
      else if (r <= hi_edge)
         v = 0;
      else if (r < mx)
         v = ((r - hi_edge) * 127) / (mx - hi_edge);
      else
         v = 127;
      return v[AXIS_BITS-1:0];
   endfunction

   // expected result of one sample set under the current registers
   function automatic axis_result_type predict_axis(input int a, input int b, input int c);
      axis_result_type res;
      int r;
      r = median_of(a, b, c);
      if (axis_cfg.invert)
         r = FULL_CODE - r;
      res.reading = r[SAMPLE_BITS-1:0];
      res.axis_value = scale_to_axis(r);
      return res;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         axis_cfg.lower_limit = LOWER_RESET;
         axis_cfg.center_level = CENTER_RESET;
         axis_cfg.upper_limit = UPPER_RESET;
         axis_cfg.dead_band = DEAD_RESET;
         axis_cfg.invert = 1'b0;
         pending_axis.delete();
      end else begin
         // register write transfer
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (reg_index_type'(csr_paddr[4:2]))
               REG_LOWER_LIMIT: begin
                  axis_cfg.lower_limit = csr_pwdata[CFG_BITS-1:0];
               end
               REG_CENTER_LEVEL: begin
                  axis_cfg.center_level = csr_pwdata[CFG_BITS-1:0];
               end
               REG_UPPER_LIMIT: begin
                  axis_cfg.upper_limit = csr_pwdata[CFG_BITS-1:0];
               end
               REG_DEAD_BAND: begin
                  axis_cfg.dead_band = csr_pwdata[DEAD_BITS-1:0];
               end
               REG_INVERT: begin
                  axis_cfg.invert = csr_pwdata[0];
               end
               default: begin
               end
            endcase
         end
         // result transfer against the oldest prediction
         if (rsp_valid && rsp_ready) begin
            if (pending_axis.size() == 0) begin
               fails++;
               if (fails <= 10)
                  $display("unexpected result: reading %0d axis_value %0d",
                           rsp_reading, rsp_axis_value);
            end else begin
               want = pending_axis.pop_front();
               checked++;
               if (rsp_reading !== want.reading || rsp_axis_value !== want.axis_value) begin
                  fails++;
                  if (fails <= 10)
                     $display("result %0d mismatch: reading exp %0d got %0d, axis_value exp %0d got %0d",
                              checked, want.reading, rsp_reading, want.axis_value,
                              rsp_axis_value);
               end
            end
         end
         // input transfer: queue its prediction
         if (req_valid && req_ready)
            pending_axis.push_back(predict_axis(int'(req_sample_first),
                                                int'(req_sample_second),
                                                int'(req_sample_third)));
      end
      fail_count <= fails;
      pending_count <= pending_axis.size();
      checked_count <= checked;
   end

endmodule

// ===== verif/joystick_axis_conditioner_core_tb.sv =====
// testbench top for the joystick axis conditioner: stimulus, register setup and verdict
module joystick_axis_conditioner_core_tb;
   import joyac_pkg::*;

   localparam int SAMPLE_BITS = 12;
   localparam int FULL_CODE   = (1 << SAMPLE_BITS) - 1;
   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_CYCLES = 14;

   logic                              clock;
   logic                              reset;
   logic                              csr_psel;
   logic                              csr_penable;
   logic                              csr_pwrite;
   logic [CSR_ADDR_BITS-1:0]          csr_paddr;
   logic [CSR_DATA_BITS-1:0]          csr_pwdata;
   logic [CSR_DATA_BITS-1:0]          csr_prdata;
   logic                              csr_pready;
   logic                              req_valid;
   logic                              req_ready;
   logic [SAMPLE_BITS-1:0]            req_sample_first;
   logic [SAMPLE_BITS-1:0]            req_sample_second;
   logic [SAMPLE_BITS-1:0]            req_sample_third;
   logic                              rsp_valid;
   logic                              rsp_ready;
   logic [SAMPLE_BITS-1:0]            rsp_reading;
   logic signed [AXIS_BITS-1:0]       rsp_axis_value;

   int fail_count;
   int pending_count;
   int checked_count;

   int sender_idle_pct = 19;
   int sink_idle_pct = 50;
   int items_sent = 0;
   int settings_count = 0;
   int cycle_count = 0;

   // local copy of the registers, used only to aim the stimulus
   int  cur_lower = 900;
   int  cur_center = 1910;
   int  cur_upper = 2900;
   int  cur_dead = 0;
   bit  cur_invert = 1'b0;

   joystick_axis_conditioner_core #(.SAMPLE_BITS(SAMPLE_BITS)) dut (
      .clock             (clock),
      .reset             (reset),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_sample_first  (req_sample_first),
      .req_sample_second (req_sample_second),
      .req_sample_third  (req_sample_third),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_reading       (rsp_reading),
      .rsp_axis_value    (rsp_axis_value)
   );

   joystick_axis_conditioner_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_checker (
      .clock             (clock),
      .reset             (reset),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_pready        (csr_pready),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_sample_first  (req_sample_first),
      .req_sample_second (req_sample_second),
      .req_sample_third  (req_sample_third),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_reading       (rsp_reading),
      .rsp_axis_value    (rsp_axis_value),
      .fail_count        (fail_count),
      .pending_count     (pending_count),
      .checked_count     (checked_count)
   );

   // clock
   initial clock = 1'b0;
   always #6 clock = ~clock;

   // receiver backpressure
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= sink_idle_pct);
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, pending_count);
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // upper bits above the register width are noise that must be ignored
   function automatic logic [CSR_DATA_BITS-1:0] with_noise(input int value, input int width);
      logic [CSR_DATA_BITS-1:0] w;
      w = $urandom();
      w = (w << width) | CSR_DATA_BITS'(value);
      return w;
   endfunction

   // one register write: setup phase, access phase, then a quiet phase
   task automatic write_reg(input reg_index_type idx, input logic [CSR_DATA_BITS-1:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
   endtask

   // hold off the sender until every result is back, then let the pipe settle
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic program_axis(input int lo, input int ce, input int up, input int db,
                               input bit inv);
      wait_idle();
      write_reg(REG_LOWER_LIMIT, with_noise(lo, CFG_BITS));
      write_reg(REG_CENTER_LEVEL, with_noise(ce, CFG_BITS));
      write_reg(REG_UPPER_LIMIT, with_noise(up, CFG_BITS));
      write_reg(REG_DEAD_BAND, with_noise(db, DEAD_BITS));
      write_reg(REG_INVERT, with_noise(int'(inv), 1));
      cur_lower = lo;
      cur_center = ce;
      cur_upper = up;
      cur_dead = db;
      cur_invert = inv;
      settings_count++;
   endtask

   // one sample set transfer, with a random gap ahead of it
   task automatic send_axis(input int a, input int b, input int c);
      int gap;
      gap = 0;
      while ($urandom_range(0, 99) < sender_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_sample_first <= a[SAMPLE_BITS-1:0];
      req_sample_second <= b[SAMPLE_BITS-1:0];
      req_sample_third <= c[SAMPLE_BITS-1:0];
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   // random sample set, mostly aimed at the region edges of the current setting
   task automatic send_random();
      int r;
      int m;
      int x;
      int y;
      int edge_pt;
      if ($urandom_range(0, 3) == 0) begin
         r = $urandom_range(0, FULL_CODE);
      end else begin
         case ($urandom_range(0, 6))
            0: edge_pt = cur_lower;
            1: edge_pt = cur_center - cur_dead;
            2: edge_pt = cur_center;
            3: edge_pt = cur_center + cur_dead;
            4: edge_pt = cur_upper;
            5: edge_pt = 0;
            default: edge_pt = FULL_CODE;
         endcase
         r = edge_pt + $urandom_range(0, 8) - 4;
         if (r < 0) r = 0;
         if (r > FULL_CODE) r = FULL_CODE;
      end
      m = cur_invert ? FULL_CODE - r : r;
      if ($urandom_range(0, 4) == 0) begin
         send_axis($urandom_range(0, FULL_CODE), $urandom_range(0, FULL_CODE),
                   $urandom_range(0, FULL_CODE));
      end else begin
         x = $urandom_range(0, m);
         y = $urandom_range(m, FULL_CODE);
         case ($urandom_range(0, 5))
            0: send_axis(m, x, y);
            1: send_axis(m, y, x);
            2: send_axis(x, m, y);
            3: send_axis(y, m, x);
            4: send_axis(x, y, m);
            default: send_axis(y, x, m);
         endcase
      end
   endtask

   // random register setting: ordered, extreme or anything at all
   task automatic random_config();
      int lo;
      int ce;
      int up;
      int db;
      case ($urandom_range(0, 5))
         0: begin
            program_axis($urandom_range(0, FULL_CODE), $urandom_range(0, FULL_CODE),
                         $urandom_range(0, FULL_CODE), $urandom_range(0, 2047),
                         $urandom_range(0, 1));
         end
         1: begin
            program_axis(0, $urandom_range(0, FULL_CODE), FULL_CODE,
                         $urandom_range(0, 1) ? 2047 : 0, $urandom_range(0, 1));
         end
         default: begin
            db = $urandom_range(0, 300);
            ce = $urandom_range(db + 1, FULL_CODE - 1 - db);
            lo = $urandom_range(0, ce - db - 1);
            up = $urandom_range(ce + db + 1, FULL_CODE);
            program_axis(lo, ce, up, db, $urandom_range(0, 1));
         end
      endcase
   endtask

   // stimulus and verdict
   initial begin
      reset <= 1'b1;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= '0;
      csr_pwdata <= '0;
      req_valid <= 1'b0;
      req_sample_first <= '0;
      req_sample_second <= '0;
      req_sample_third <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset setting: region edges and median orderings
      send_axis(0, 0, 0);
      send_axis(FULL_CODE, FULL_CODE, FULL_CODE);
      send_axis(900, 900, 900);
      send_axis(901, 5, 4000);
      send_axis(1909, 1909, 1909);
      send_axis(1910, 1910, 1910);
      send_axis(1911, 0, FULL_CODE);
      send_axis(2899, 2899, 2899);
      send_axis(2900, 2900, 2900);
      send_axis(3, 1, 2);
      send_axis(4000, 2000, 100);
      send_axis(2500, FULL_CODE, 0);
      send_axis(1400, 1400, 3000);
      send_axis(12'hAAA, 12'h555, 12'hFFF);

      // inverted, full-range limits with a dead band
      program_axis(0, 2048, FULL_CODE, 100, 1'b1);
      send_axis(0, 0, 0);
      send_axis(FULL_CODE, FULL_CODE, FULL_CODE);
      send_axis(2148, 2148, 2148);
      send_axis(1947, 1947, 1947);

      // misordered limits with the widest dead band
      program_axis(3000, 1000, 500, 2047, 1'b0);
      send_axis(2999, 2999, 2999);
      send_axis(3000, 3000, 3000);
      send_axis(3500, 3500, 3500);

      // all-ones and all-zero limit extremes
      program_axis(FULL_CODE, FULL_CODE, 0, 2047, 1'b1);
      send_axis(1234, 1234, 1234);
      program_axis(0, 0, 0, 0, 1'b0);
      send_axis(0, 0, 0);
      send_axis(5, 5, 5);

      // random part in three idle mixes
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin sender_idle_pct = 19; sink_idle_pct = 50; end
            1: begin sender_idle_pct = 50; sink_idle_pct = 19; end
            default: begin sender_idle_pct = 0; sink_idle_pct = 0; end
         endcase
         for (int seg = 0; seg < 4; seg++) begin
            random_config();
            for (int n = 0; n < 42; n++) begin
               if (phase == 0 && seg == 0 && n == 20)
                  wait_idle();
               send_random();
            end
         end
      end

      // drain and settle
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d sample set transfers over %0d register settings",
               items_sent, settings_count + 1);
      $display("%0d results compared; inverted, misordered and extreme limits, three idle mixes",
               checked_count);
      if (fail_count == 0 && pending_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("%0d failures, %0d results never arrived", fail_count, pending_count);
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// ===== joystick_axis_conditioner_core.f =====
design/joyac_pkg.sv
design/joyac_front.sv
design/joyac_cell.sv
design/joystick_axis_conditioner_core.sv
verif/joystick_axis_conditioner_checker.sv
verif/joystick_axis_conditioner_core_tb.sv
